// File: rtl/core/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg - shared types and constants for the Playfair digraph decrypt unit
// Letter codes, key square layout, register map and a small mod-5 helper.
// ----------------------------------------------------------------------------
package pfd_pkg;

	// letter codes are five bits, A=0 through Z=25
	localparam int LETTER_W = 5;
	localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;

	// key square geometry
	localparam int SIDE  = 5;
	localparam int POS_W = 3;   // row or column index, 0..SIDE-1
	localparam logic [POS_W-1:0] POS_LAST = 3'(SIDE - 1);

	// register widths
	localparam int KEY_ROW2_W = 2 * SIDE * LETTER_W;   // ten cells
	localparam int KEY_ROW1_W = SIDE * LETTER_W;       // five cells
	localparam int KEY_FLAT_W = SIDE * SIDE * LETTER_W;

	// configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;
	localparam int REG_SEL_W = 2;
	localparam logic [REG_SEL_W-1:0] REG_KEY_0_9   = 2'd0;
	localparam logic [REG_SEL_W-1:0] REG_KEY_10_19 = 2'd1;
	localparam logic [REG_SEL_W-1:0] REG_KEY_20_24 = 2'd2;

	// key square indexed [row][column]
	typedef logic [SIDE-1:0][SIDE-1:0][LETTER_W-1:0] key_square_t;

	// result of looking up one letter in the square
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} loc_t;

	// step one place back around the square, with wrap
	function automatic logic [POS_W-1:0] dec_mod5(input logic [POS_W-1:0] v);
		logic [POS_W-1:0] r;
		if (v == '0) begin
			r = POS_LAST;
		end else begin
			r = v - POS_W'(1);
		end
		return r;
	endfunction

endpackage

// File: rtl/core/pfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// pfd_cfg_regs - key square configuration registers
// APB-style write/read of the three key registers; presents the square
// as a row/column array.
// ----------------------------------------------------------------------------
module pfd_cfg_regs
	import pfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output key_square_t       key_sq
);

	logic [KEY_ROW2_W-1:0] key_0_9_q;
	logic [KEY_ROW2_W-1:0] key_10_19_q;
	logic [KEY_ROW1_W-1:0] key_20_24_q;
	logic [REG_SEL_W-1:0]  reg_sel;
	logic                  wr_en;
	logic [KEY_FLAT_W-1:0] key_flat;

	assign pready  = 1'b1;
	assign reg_sel = paddr[ADDR_W-1:ADDR_W-REG_SEL_W];
	assign wr_en   = psel & penable & pwrite;

	// write the selected key register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_0_9_q   <= '0;
			key_10_19_q <= '0;
			key_20_24_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_KEY_0_9:   key_0_9_q   <= pwdata[KEY_ROW2_W-1:0];
				REG_KEY_10_19: key_10_19_q <= pwdata[KEY_ROW2_W-1:0];
				REG_KEY_20_24: key_20_24_q <= pwdata[KEY_ROW1_W-1:0];
				default: ;
			endcase
		end
	end

	// read back, zero-extended
	always_comb begin
		unique case (reg_sel)
			REG_KEY_0_9:   prdata = DATA_W'(key_0_9_q);
			REG_KEY_10_19: prdata = DATA_W'(key_10_19_q);
			REG_KEY_20_24: prdata = DATA_W'(key_20_24_q);
			default:       prdata = '0;
		endcase
	end

	// lay the cells out row-major as [row][column]
	assign key_flat = {key_20_24_q, key_10_19_q, key_0_9_q};

	always_comb begin
		for (int r = 0; r < SIDE; r++) begin
			for (int c = 0; c < SIDE; c++) begin
				key_sq[r][c] = key_flat[(r*SIDE + c)*LETTER_W +: LETTER_W];
			end
		end
	end

endmodule

// File: rtl/core/pfd_locate.sv
// ----------------------------------------------------------------------------
// pfd_locate - find a letter in the key square
// Compares the letter against all cells at once; the lowest cell wins.
// ----------------------------------------------------------------------------
module pfd_locate
	import pfd_pkg::*;
(
	input  key_square_t         key_sq,
	input  logic [LETTER_W-1:0] letter,
	output loc_t                loc
);

	// scan from the last cell down so the lowest match overrides
	always_comb begin
		loc = '0;
		for (int r = SIDE - 1; r >= 0; r--) begin
			for (int c = SIDE - 1; c >= 0; c--) begin
				if (key_sq[r][c] == letter) begin
					loc.found = 1'b1;
					loc.row   = POS_W'(r);
					loc.col   = POS_W'(c);
				end
			end
		end
	end

endmodule

// File: rtl/core/pfd_core.sv
// ----------------------------------------------------------------------------
// pfd_core - digraph decrypt datapath
// Locates both letters, applies the row, column or rectangle rule and
// fills plaintext X from the preceding letter.
// ----------------------------------------------------------------------------
module pfd_core
	import pfd_pkg::*;
(
	input  key_square_t         key_sq,
	input  logic [LETTER_W-1:0] cipher_a,
	input  logic [LETTER_W-1:0] cipher_b,
	input  logic                start,
	input  logic [LETTER_W-1:0] prev_letter,
	output logic [LETTER_W-1:0] plain_a,
	output logic [LETTER_W-1:0] plain_b,
	output logic                not_in_key
);

	loc_t             loc_a;
	loc_t             loc_b;
	logic [POS_W-1:0] row_a, col_a, row_b, col_b;
	logic [LETTER_W-1:0] raw_a, raw_b, fill_a;

	pfd_locate u_locate_a (
		.key_sq (key_sq),
		.letter (cipher_a),
		.loc    (loc_a)
	);

	pfd_locate u_locate_b (
		.key_sq (key_sq),
		.letter (cipher_b),
		.loc    (loc_b)
	);

	// pick the cell of each plaintext letter
	always_comb begin
		if (loc_a.row == loc_b.row) begin
			row_a = loc_a.row;
			row_b = loc_b.row;
			col_a = dec_mod5(loc_a.col);
			col_b = dec_mod5(loc_b.col);
		end else if (loc_a.col == loc_b.col) begin
			row_a = dec_mod5(loc_a.row);
			row_b = dec_mod5(loc_b.row);
			col_a = loc_a.col;
			col_b = loc_b.col;
		end else begin
			row_a = loc_a.row;
			row_b = loc_b.row;
			col_a = loc_b.col;
			col_b = loc_a.col;
		end
	end

	assign raw_a = key_sq[row_a][col_a];
	assign raw_b = key_sq[row_b][col_b];

	// fill X: first from the previous letter unless at message start, second from the first
	assign fill_a = (raw_a == LETTER_X && !start) ? prev_letter : raw_a;

	assign not_in_key = !(loc_a.found && loc_b.found);

	always_comb begin
		if (not_in_key) begin
			plain_a = '0;
			plain_b = '0;
		end else begin
			plain_a = fill_a;
			plain_b = (raw_b == LETTER_X) ? fill_a : raw_b;
		end
	end

endmodule

// File: rtl/core/playfair_digraph_decrypt_unit.sv
// ----------------------------------------------------------------------------
// playfair_digraph_decrypt_unit - Playfair digraph decryption, one per cycle unless stalled
// Input register, single-pass decrypt logic and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one ciphertext digraph and a
//   start-of-message flag per request. Output channel (out_valid/out_stall)
//   returns the two plaintext letters and a flag that is set when either
//   letter is missing from the key square (letters then read as zero).
//   The key square is loaded through the APB-style port: cells 0..9 at
//   address 0, cells 10..19 at 8, cells 20..24 at 16. Write it only while
//   no request is in flight.
//   A request goes through the input register, then the result register;
//   out_valid rises when the result register loads, which a stall can
//   hold off. Throughput is one digraph per cycle while out_stall is low;
//   the carried previous plaintext letter is updated in the same cycle
//   the result register loads (not on a miss); back-to-back digraphs chain.
//   When the receiver stalls, the result register holds, then the input
//   register fills and in_stall rises; no request is dropped.
//   Reset clears the key square, both valid bits and the previous letter.
// ----------------------------------------------------------------------------
module playfair_digraph_decrypt_unit
	import pfd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [LETTER_W-1:0] first_cipher_letter,
	input  logic [LETTER_W-1:0] second_cipher_letter,
	input  logic                start_of_message,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [LETTER_W-1:0] first_plain_letter,
	output logic [LETTER_W-1:0] second_plain_letter,
	output logic                letter_not_in_key
);

	key_square_t         key_sq;
	logic                valid_s1;
	logic [LETTER_W-1:0] cipher_a_s1, cipher_b_s1;
	logic                start_s1;
	logic                valid_s2;
	logic [LETTER_W-1:0] plain_a_s2, plain_b_s2;
	logic                miss_s2;
	logic [LETTER_W-1:0] prev_q;
	logic [LETTER_W-1:0] plain_a, plain_b;
	logic                miss;
	logic                s2_ready, s1_ready, s1_move, in_take;

	pfd_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.key_sq  (key_sq)
	);

	// handshake: each stage loads when empty or when it drains
	assign s2_ready = !valid_s2 || !out_stall;
	assign s1_move  = valid_s1 && s2_ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign in_stall = !s1_ready;
	assign in_take  = in_valid && s1_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cipher_a_s1 <= first_cipher_letter;
			cipher_b_s1 <= second_cipher_letter;
			start_s1    <= start_of_message;
		end
	end

	pfd_core u_core (
		.key_sq      (key_sq),
		.cipher_a    (cipher_a_s1),
		.cipher_b    (cipher_b_s1),
		.start       (start_s1),
		.prev_letter (prev_q),
		.plain_a     (plain_a),
		.plain_b     (plain_b),
		.not_in_key  (miss)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			plain_a_s2 <= plain_a;
			plain_b_s2 <= plain_b;
			miss_s2    <= miss;
		end
	end

	// carry the last plaintext letter; hold it when a letter was missing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (s1_move && !miss) begin
			prev_q <= plain_b;
		end
	end

	assign out_valid           = valid_s2;
	assign first_plain_letter  = plain_a_s2;
	assign second_plain_letter = plain_b_s2;
	assign letter_not_in_key   = miss_s2;

endmodule

// File: bench/playfair_digraph_decrypt_unit_test.sv
// ----------------------------------------------------------------------------
// playfair_digraph_decrypt_unit_test - self-checking bench for the decrypt unit
// Loads key squares over the APB-style port and streams ciphertext digraphs
// with random gaps and random output stalls. A digraph-level predictor keeps
// its own copy of the key square and the carried plaintext letter, and every
// result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module playfair_digraph_decrypt_unit_test;
	import pfd_pkg::*;

	localparam int CELL_COUNT = SIDE * SIDE;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 4;
	localparam int KEYS_IN_RANDOM = 6;
	localparam int ITEMS_PER_KEY = 180;

	typedef logic [LETTER_W-1:0] letter_t;

	typedef struct packed {
		letter_t first;
		letter_t second;
		logic    miss;
	} plain_digraph_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_stall;
	letter_t             first_cipher_letter;
	letter_t             second_cipher_letter;
	logic                start_of_message;
	logic                out_valid;
	logic                out_stall;
	letter_t             first_plain_letter;
	letter_t             second_plain_letter;
	logic                letter_not_in_key;

	// predictor state: key square and carried plaintext letter
	letter_t key_cell [CELL_COUNT];
	letter_t next_key [CELL_COUNT];
	letter_t carried_plain;
	plain_digraph_t expected_plain [$];

	int  mismatch_count;
	int  idle_cycles;
	bit  quiet_tx;
	bit  quiet_rx;
	int  stall_hold;

	playfair_digraph_decrypt_unit u_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.psel                 (psel),
		.penable              (penable),
		.pwrite               (pwrite),
		.paddr                (paddr),
		.pwdata               (pwdata),
		.prdata               (prdata),
		.pready               (pready),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.first_cipher_letter  (first_cipher_letter),
		.second_cipher_letter (second_cipher_letter),
		.start_of_message     (start_of_message),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.first_plain_letter   (first_plain_letter),
		.second_plain_letter  (second_plain_letter),
		.letter_not_in_key    (letter_not_in_key)
	);

	// free-running clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// find the lowest cell holding a letter, -1 when absent
	function automatic int find_cell(letter_t code);
		int pos;
		pos = -1;
		for (int k = CELL_COUNT - 1; k >= 0; k--) begin
			if (key_cell[k] == code) begin
				pos = k;
			end
		end
		return pos;
	endfunction

	// decrypt one digraph and advance the carried letter unless a letter misses
	function automatic plain_digraph_t decrypt_digraph(letter_t ca, letter_t cb, logic som);
		plain_digraph_t r;
		int pos_a, pos_b, ra, ka, rb, kb;
		r = '0;
		pos_a = find_cell(ca);
		pos_b = find_cell(cb);
		if (pos_a < 0 || pos_b < 0) begin
			r.miss = 1'b1;
			return r;
		end
		ra = pos_a / SIDE;
		ka = pos_a % SIDE;
		rb = pos_b / SIDE;
		kb = pos_b % SIDE;
		if (ra == rb) begin
			r.first  = key_cell[ra * SIDE + (ka + SIDE - 1) % SIDE];
			r.second = key_cell[rb * SIDE + (kb + SIDE - 1) % SIDE];
		end else if (ka == kb) begin
			r.first  = key_cell[((ra + SIDE - 1) % SIDE) * SIDE + ka];
			r.second = key_cell[((rb + SIDE - 1) % SIDE) * SIDE + kb];
		end else begin
			r.first  = key_cell[ra * SIDE + kb];
			r.second = key_cell[rb * SIDE + ka];
		end
		// fill X from the letter before it
		if (r.first == LETTER_X && !som) begin
			r.first = carried_plain;
		end
		if (r.second == LETTER_X) begin
			r.second = r.first;
		end
		carried_plain = r.second;
		return r;
	endfunction

	// mostly short gaps, some medium, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 30);
	endfunction

	// prefer letters present in the key, otherwise any letter
	function automatic letter_t pick_cipher();
		letter_t c;
		if ($urandom_range(0, 99) < 85) begin
			for (int tries = 0; tries < 8; tries++) begin
				c = key_cell[$urandom_range(0, CELL_COUNT - 1)];
				if (c <= 25) begin
					return c;
				end
			end
		end
		return letter_t'($urandom_range(0, 25));
	endfunction

	// write one key register through setup and access cycles
	task automatic write_key_reg(logic [REG_SEL_W-1:0] sel, logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (sel)
			REG_KEY_0_9: begin
				for (int k = 0; k < 10; k++) key_cell[k] = value[5 * k +: LETTER_W];
			end
			REG_KEY_10_19: begin
				for (int k = 0; k < 10; k++) key_cell[10 + k] = value[5 * k +: LETTER_W];
			end
			REG_KEY_20_24: begin
				for (int k = 0; k < 5; k++) key_cell[20 + k] = value[5 * k +: LETTER_W];
			end
			default: begin
			end
		endcase
	endtask

	// pack the staged square and write all three registers
	task automatic load_key();
		logic [DATA_W-1:0] v0, v1, v2;
		v0 = '0;
		v1 = '0;
		v2 = '0;
		for (int k = 0; k < 10; k++) begin
			v0[5 * k +: LETTER_W] = next_key[k];
			v1[5 * k +: LETTER_W] = next_key[10 + k];
		end
		for (int k = 0; k < 5; k++) v2[5 * k +: LETTER_W] = next_key[20 + k];
		write_key_reg(REG_KEY_0_9, v0);
		write_key_reg(REG_KEY_10_19, v1);
		write_key_reg(REG_KEY_20_24, v2);
	endtask

	// stage a square from a 25-letter string
	task automatic stage_key_text(string s);
		for (int k = 0; k < CELL_COUNT; k++) next_key[k] = letter_t'(s[k] - 8'd65);
	endtask

	// stage a random square: permutation, duplicates or raw codes
	task automatic stage_random_key(int kind);
		letter_t pool [26];
		letter_t t;
		int j;
		for (int i = 0; i < 26; i++) pool[i] = letter_t'(i);
		for (int i = 25; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = pool[i];
			pool[i] = pool[j];
			pool[j] = t;
		end
		for (int k = 0; k < CELL_COUNT; k++) next_key[k] = pool[k];
		if (kind == 1) begin
			for (int k = 0; k < CELL_COUNT; k++) next_key[k] = letter_t'($urandom_range(0, 31));
		end else if (kind == 2) begin
			repeat (4) next_key[$urandom_range(0, CELL_COUNT - 1)] =
				next_key[$urandom_range(0, CELL_COUNT - 1)];
		end
	endtask

	// send one request and record its prediction at acceptance
	task automatic send_digraph(letter_t ca, letter_t cb, logic som);
		int gap;
		gap = quiet_tx ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid             <= 1'b1;
		first_cipher_letter  <= ca;
		second_cipher_letter <= cb;
		start_of_message     <= som;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_plain.push_back(decrypt_digraph(ca, cb, som));
	endtask

	// drop valid and hold until every result is back and the pipe is empty
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_plain.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// reset square is all A: only A is found, everything else misses
	task automatic test_reset_key();
		send_digraph(letter_t'(0), letter_t'(0), 1'b1);
		send_digraph(letter_t'(1), letter_t'(0), 1'b0);
		send_digraph(letter_t'(25), letter_t'(25), 1'b0);
		wait_drained();
	endtask

	// classic square without J, each rule and X filling case
	task automatic test_classic_key();
		stage_key_text("PLAYFIREXMBCDGHKNOQSTUVWZ");
		load_key();
		// rectangle giving a leading X before any message start
		send_digraph(letter_t'(8), letter_t'(6), 1'b0);
		// same row, wrap from the first column
		send_digraph(letter_t'(15), letter_t'(0), 1'b1);
		// same column, wrap from the top row
		send_digraph(letter_t'(15), letter_t'(8), 1'b0);
		// same column inside the square
		send_digraph(letter_t'(4), letter_t'(3), 1'b0);
		// both letters equal
		send_digraph(letter_t'(25), letter_t'(25), 1'b0);
		// leading X kept at message start
		send_digraph(letter_t'(8), letter_t'(6), 1'b1);
		// trailing X takes the first letter
		send_digraph(letter_t'(6), letter_t'(8), 1'b0);
		// both X: chain through the carried letter
		send_digraph(letter_t'(12), letter_t'(12), 1'b0);
		send_digraph(letter_t'(12), letter_t'(12), 1'b1);
		// letters missing from the square
		send_digraph(letter_t'(9), letter_t'(0), 1'b0);
		send_digraph(letter_t'(0), letter_t'(9), 1'b0);
		send_digraph(letter_t'(9), letter_t'(9), 1'b1);
		// carried letter survives a miss
		send_digraph(letter_t'(8), letter_t'(6), 1'b0);
		// extreme codes
		send_digraph(letter_t'(0), letter_t'(25), 1'b0);
		send_digraph(letter_t'(25), letter_t'(0), 1'b1);
		send_digraph(letter_t'(24), letter_t'(15), 1'b0);
		wait_drained();
	endtask

	// duplicate cells, codes above Z, all-ones and all-zero registers
	task automatic test_odd_keys();
		stage_random_key(2);
		for (int k = 0; k < CELL_COUNT; k++) begin
			if (k % 4 == 1) next_key[k] = next_key[k - 1];
		end
		load_key();
		repeat (6) send_digraph(pick_cipher(), pick_cipher(), 1'($urandom_range(0, 1)));
		wait_drained();
		for (int k = 0; k < CELL_COUNT; k++) begin
			next_key[k] = (k % 3 == 0) ? letter_t'(26 + k % 6) : letter_t'(k);
		end
		load_key();
		repeat (6) send_digraph(pick_cipher(), pick_cipher(), 1'($urandom_range(0, 1)));
		wait_drained();
		write_key_reg(REG_KEY_0_9, DATA_W'({KEY_ROW2_W{1'b1}}));
		write_key_reg(REG_KEY_10_19, DATA_W'({KEY_ROW2_W{1'b1}}));
		write_key_reg(REG_KEY_20_24, DATA_W'({KEY_ROW1_W{1'b1}}));
		send_digraph(letter_t'(0), letter_t'(25), 1'b0);
		send_digraph(letter_t'(25), letter_t'(0), 1'b1);
		wait_drained();
		write_key_reg(REG_KEY_0_9, '0);
		write_key_reg(REG_KEY_10_19, '0);
		write_key_reg(REG_KEY_20_24, '0);
		send_digraph(letter_t'(0), letter_t'(0), 1'b0);
		send_digraph(letter_t'(0), letter_t'(16), 1'b0);
		wait_drained();
	endtask

	// random text under several squares, draining before each key change
	task automatic test_random_text();
		int kind;
		for (int key_no = 0; key_no < KEYS_IN_RANDOM; key_no++) begin
			kind = $urandom_range(0, 99) < 60 ? 0 : $urandom_range(1, 2);
			stage_random_key(kind);
			load_key();
			quiet_tx = ($urandom_range(0, 3) == 0);
			quiet_rx = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < ITEMS_PER_KEY; i++) begin
				send_digraph(pick_cipher(), pick_cipher(),
					(i == 0) || ($urandom_range(0, 99) < 8));
			end
			quiet_tx = 1'b0;
			quiet_rx = 1'b0;
			wait_drained();
		end
	endtask

	// random receiver stalls: runs of free flow, short stalls, rare long ones
	always @(posedge clk) begin : drive_out_stall
		int r;
		if (quiet_rx) begin
			out_stall  <= 1'b0;
			stall_hold <= 0;
		end else if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				out_stall  <= 1'b0;
				stall_hold <= $urandom_range(0, 8);
			end else if (r < 93) begin
				out_stall  <= 1'b1;
				stall_hold <= $urandom_range(0, 2);
			end else begin
				out_stall  <= 1'b1;
				stall_hold <= $urandom_range(10, 40);
			end
		end
	end

	// check each accepted result against the oldest prediction
	always @(posedge clk) begin : check_result
		plain_digraph_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_plain.size() == 0) begin
				$display("%0t: result with no request pending: %0d %0d %0d", $time,
					first_plain_letter, second_plain_letter, letter_not_in_key);
				mismatch_count++;
			end else begin
				want = expected_plain.pop_front();
				if (first_plain_letter !== want.first) begin
					$display("%0t: first_plain_letter expected %0d actual %0d", $time,
						want.first, first_plain_letter);
					mismatch_count++;
				end
				if (second_plain_letter !== want.second) begin
					$display("%0t: second_plain_letter expected %0d actual %0d", $time,
						want.second, second_plain_letter);
					mismatch_count++;
				end
				if (letter_not_in_key !== want.miss) begin
					$display("%0t: letter_not_in_key expected %0d actual %0d", $time,
						want.miss, letter_not_in_key);
					mismatch_count++;
				end
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n               = 1'b0;
		psel                 <= 1'b0;
		penable              <= 1'b0;
		pwrite               <= 1'b0;
		paddr                <= '0;
		pwdata               <= '0;
		in_valid             <= 1'b0;
		first_cipher_letter  <= '0;
		second_cipher_letter <= '0;
		start_of_message     <= 1'b0;
		out_stall            <= 1'b0;
		stall_hold           = 0;
		idle_cycles          = 0;
		mismatch_count       = 0;
		quiet_tx             = 1'b0;
		quiet_rx             = 1'b0;
		carried_plain        = '0;
		for (int k = 0; k < CELL_COUNT; k++) key_cell[k] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_key();
		test_classic_key();
		test_odd_keys();
		test_random_text();

		// drain and let the pipe settle before the verdict
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: playfair_digraph_decrypt_unit.f
rtl/core/pfd_pkg.sv
rtl/core/pfd_cfg_regs.sv
rtl/core/pfd_locate.sv
rtl/core/pfd_core.sv
rtl/core/playfair_digraph_decrypt_unit.sv
bench/playfair_digraph_decrypt_unit_test.sv
